FILE: hw/rtl/e2efc_pkg.sv
package e2efc_pkg;

  localparam logic [7:0] CRC_POLY   = 8'h1D;
  localparam logic [3:0] MIN_LEN    = 4'd2;
  localparam logic [7:0] FAIL_MAX   = 8'hFF;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_BADPDU  = 3'd2;
  localparam logic [2:0] ST_CRC     = 3'd3;
  localparam logic [2:0] ST_SEQ     = 3'd4;

  typedef struct packed {
    logic [7:0] pdu_id;
    logic [7:0] data_id;
    logic [3:0] frame_length;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [7:0] byte6;
    logic [7:0] byte7;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] fail_total;
    logic [7:0] computed_crc;
  } out_item_t;

  // per-PDU record: alive counter and consecutive fail count
  typedef struct packed {
    logic [3:0] alive;
    logic [7:0] fail;
  } slot_rec_t;

  typedef struct packed {
    logic       start;
    logic [2:0] nbytes;
    logic [7:0] init;
  } crc_cmd_t;

endpackage

FILE: hw/rtl/e2e_frame_check.sv
// Receive-side E2E check, one CAN frame per transaction. The CRC-8 (poly 0x1D,
// init data_id) runs one frame byte per cycle in a shift register, so a frame
// of length L goes through accept, min(L,MAX_FRAME_BYTES)-1 CRC bytes, settle
// and result; rejected frames (short or bad PDU index) run no CRC bytes.
// One frame is in work at a time; the result sits in an output register so the
// next frame can be taken while it waits. Per-PDU alive and fail counts live in
// a small memory with per-entry valid bits, so reset clears them at once.
module e2e_frame_check #(
  parameter int PDU_SLOTS       = 16,
  parameter int MAX_FRAME_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  e2efc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output e2efc_pkg::out_item_t out_data
);

  localparam int         SLOT_W   = (PDU_SLOTS > 1) ? $clog2(PDU_SLOTS) : 1;
  localparam logic [8:0] SLOT_LIM = 9'(PDU_SLOTS);
  localparam logic [3:0] MAX_LEN  = 4'(MAX_FRAME_BYTES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic                 accept;
  logic                 in_range, is_short;
  logic [3:0]           len_eff;
  e2efc_pkg::crc_cmd_t  crc_cmd;
  logic                 crc_busy;
  logic [7:0]           crc_val;

  logic [SLOT_W-1:0]    idx_r;
  logic                 in_range_r, short_r;
  logic [7:0]           byte0_r;
  logic [3:0]           rx_alive_r;

  e2efc_pkg::slot_rec_t rec, wr_rec;
  logic                 fin_go, wr_en;
  logic [7:0]           fail_inc;
  logic [3:0]           exp_alive;

  e2efc_pkg::out_item_t res, out_r;
  logic                 out_valid_r, out_valid_nxt;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  assign in_range = ({1'b0, in_data.pdu_id} < SLOT_LIM);
  assign is_short = (in_data.frame_length < e2efc_pkg::MIN_LEN);
  assign len_eff  = (in_data.frame_length > MAX_LEN) ? MAX_LEN : in_data.frame_length;

  always_comb begin
    crc_cmd.start  = accept;
    crc_cmd.init   = in_data.data_id;
    crc_cmd.nbytes = (is_short || !in_range) ? 3'd0 : 3'(len_eff - 4'd1);
  end

  e2efc_crc_serial u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (crc_cmd),
    .bytes ({in_data.byte7, in_data.byte6, in_data.byte5, in_data.byte4,
             in_data.byte3, in_data.byte2, in_data.byte1}),
    .busy  (crc_busy),
    .crc   (crc_val)
  );

  e2efc_slot_store #(
    .PDU_SLOTS (PDU_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_idx  (in_data.pdu_id[SLOT_W-1:0]),
    .rd_data (rec),
    .wr_en   (wr_en),
    .wr_idx  (idx_r),
    .wr_data (wr_rec)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r      <= in_data.pdu_id[SLOT_W-1:0];
      in_range_r <= in_range;
      short_r    <= is_short;
      byte0_r    <= in_data.byte0;
      rx_alive_r <= in_data.byte1[3:0];
    end
  end

  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign fail_inc  = (rec.fail == e2efc_pkg::FAIL_MAX) ? rec.fail : rec.fail + 8'd1;
  assign exp_alive = rec.alive + 4'd1;

  always_comb begin
    res          = '0;
    wr_rec       = rec;
    wr_en        = 1'b0;
    if (short_r) begin
      res.status     = e2efc_pkg::ST_SHORT;
      res.fail_total = in_range_r ? rec.fail : 8'd0;
    end else if (!in_range_r) begin
      res.status     = e2efc_pkg::ST_BADPDU;
    end else begin
      wr_en            = fin_go;
      res.computed_crc = crc_val;
      if (crc_val != byte0_r) begin
        res.status  = e2efc_pkg::ST_CRC;
        wr_rec.fail = fail_inc;
      end else begin
        wr_rec.alive = rx_alive_r;
        if (rx_alive_r != exp_alive) begin
          res.status  = e2efc_pkg::ST_SEQ;
          wr_rec.fail = fail_inc;
        end else begin
          res.status  = e2efc_pkg::ST_OK;
          wr_rec.fail = 8'd0;
        end
      end
      res.fail_total = wr_rec.fail;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (!crc_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hw/rtl/e2efc_crc_serial.sv
module e2efc_crc_serial (
  input  logic                clk,
  input  logic                rst_n,
  input  e2efc_pkg::crc_cmd_t cmd,
  input  logic [55:0]         bytes,   // byte1 in [7:0] .. byte7 in [55:48]
  output logic                busy,
  output logic [7:0]          crc
);

  logic [55:0] sh_r, sh_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;

  function automatic logic [7:0] crc_byte(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] v;
    v = c ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ e2efc_pkg::CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

  always_comb begin
    sh_nxt  = sh_r;
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    if (cmd.start) begin
      sh_nxt  = bytes;
      crc_nxt = cmd.init;
      cnt_nxt = cmd.nbytes;
    end else if (cnt_r != 3'd0) begin
      crc_nxt = crc_byte(crc_r, sh_r[7:0]);
      sh_nxt  = {8'h00, sh_r[55:8]};
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    crc_r <= crc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign busy = (cnt_r != 3'd0);
  assign crc  = crc_r;

endmodule

FILE: hw/rtl/e2efc_slot_store.sv
module e2efc_slot_store #(
  parameter int PDU_SLOTS = 16,
  parameter int SLOT_W    = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [SLOT_W-1:0]      rd_idx,
  output e2efc_pkg::slot_rec_t   rd_data,
  input  logic                   wr_en,
  input  logic [SLOT_W-1:0]      wr_idx,
  input  e2efc_pkg::slot_rec_t   wr_data
);

  e2efc_pkg::slot_rec_t mem [PDU_SLOTS];
  e2efc_pkg::slot_rec_t rd_q_r;
  logic [PDU_SLOTS-1:0] vld_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_idx];
    end
  end

  // an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_idx];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

FILE: hw/rtl/e2efc_checker.sv
module e2efc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input e2efc_pkg::out_item_t out_data
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one frame in work at a time
  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a frame is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= e2efc_pkg::ST_SEQ)
    else $error("unknown status code");

  a_badpdu_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == e2efc_pkg::ST_BADPDU
      |-> out_data.fail_total == 8'd0 && out_data.computed_crc == 8'd0)
    else $error("bad index result not zeroed");

  a_ok_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == e2efc_pkg::ST_OK |-> out_data.fail_total == 8'd0)
    else $error("good frame left a fail count");

endmodule

bind e2e_frame_check e2efc_checker u_e2efc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
